FILE: rtl/mss_pkg.sv
// ----------------------------------------------------------------------------
// mss_pkg
// Shared types, codes and the transition table of the motor state sequencer.
// ----------------------------------------------------------------------------
package mss_pkg;

   localparam int FAULT_W = 16;
   localparam int STATE_W = 5;

   // reset value of the software error mask
   localparam logic [FAULT_W-1:0] SW_ERR_MASK_RESET = 16'h0080;

   // supervisor states
   typedef enum logic [STATE_W-1:0] {
      ST_IDLE               = 5'd0,
      ST_IDLE_START         = 5'd1,
      ST_IDLE_ALIGNMENT     = 5'd2,
      ST_ICL_WAIT           = 5'd3,
      ST_ALIGN_BOOT_CAP     = 5'd4,
      ST_ALIGN_OFFSET_CALIB = 5'd5,
      ST_ALIGN_CLEAR        = 5'd6,
      ST_ALIGNMENT          = 5'd7,
      ST_BOOT_CAP           = 5'd8,
      ST_OFFSET_CALIB       = 5'd9,
      ST_WAIT_STOP          = 5'd10,
      ST_CLEAR              = 5'd11,
      ST_START              = 5'd12,
      ST_SWITCH_OVER        = 5'd13,
      ST_START_RUN          = 5'd14,
      ST_RUN                = 5'd15,
      ST_ANY_STOP           = 5'd16,
      ST_STOP               = 5'd17,
      ST_STOP_IDLE          = 5'd18,
      ST_FAULT_NOW          = 5'd19,
      ST_FAULT_OVER         = 5'd20
   } mss_state_type;

   // command codes
   typedef enum logic [1:0] {
      CMD_CHANGE_STATE = 2'd0,
      CMD_FAULT_UPDATE = 2'd1,
      CMD_FAULT_ACK    = 2'd2,
      CMD_UNUSED       = 2'd3
   } mss_cmd_type;

   // machine state and fault words after one item
   typedef struct packed {
      logic                 accepted;
      mss_state_type        state;
      logic [FAULT_W-1:0]   active;
      logic [FAULT_W-1:0]   sticky;
   } mss_result_type;

   // one bit for each state code the given state may move to
   function automatic logic [31:0] legal_targets(input mss_state_type cur);
      logic [31:0] m;
      m = '0;
      case (cur)
         ST_IDLE:               m = (32'd1 << 1) | (32'd1 << 2) | (32'd1 << 3);
         ST_IDLE_START:         m = (32'd1 << 16) | (32'd1 << 8) | (32'd1 << 12)
                                  | (32'd1 << 9) | (32'd1 << 2);
         ST_IDLE_ALIGNMENT:     m = (32'd1 << 16) | (32'd1 << 4) | (32'd1 << 5);
         ST_ICL_WAIT:           m = 32'd1;
         ST_ALIGN_BOOT_CAP:     m = (32'd1 << 5) | (32'd1 << 16);
         ST_ALIGN_OFFSET_CALIB: m = (32'd1 << 6) | (32'd1 << 16);
         ST_ALIGN_CLEAR:        m = (32'd1 << 7) | (32'd1 << 16);
         ST_ALIGNMENT:          m = (32'd1 << 16);
         ST_BOOT_CAP:           m = (32'd1 << 9) | (32'd1 << 16);
         ST_OFFSET_CALIB:       m = (32'd1 << 11) | (32'd1 << 16) | (32'd1 << 10);
         ST_WAIT_STOP:          m = (32'd1 << 11) | (32'd1 << 16);
         ST_CLEAR:              m = (32'd1 << 12) | (32'd1 << 16);
         ST_START:              m = (32'd1 << 13) | (32'd1 << 16) | (32'd1 << 14);
         ST_SWITCH_OVER:        m = (32'd1 << 12) | (32'd1 << 16) | (32'd1 << 14);
         ST_START_RUN:          m = (32'd1 << 15) | (32'd1 << 16);
         ST_RUN:                m = (32'd1 << 16);
         ST_ANY_STOP:           m = (32'd1 << 17);
         ST_STOP:               m = (32'd1 << 18);
         ST_STOP_IDLE:          m = 32'd1 | (32'd1 << 3);
         default:               m = '0;
      endcase
      return m;
   endfunction

endpackage

FILE: rtl/mss_step.sv
// ----------------------------------------------------------------------------
// mss_step
// Next machine state, fault words and accept flag for one command.
// ----------------------------------------------------------------------------
module mss_step (
   input  mss_pkg::mss_state_type              cur_state,
   input  logic [mss_pkg::FAULT_W-1:0]         cur_active,
   input  logic [mss_pkg::FAULT_W-1:0]         cur_sticky,
   input  logic [mss_pkg::FAULT_W-1:0]         sw_err_mask,
   input  logic [1:0]                          command,
   input  logic [mss_pkg::STATE_W-1:0]         requested_state,
   input  logic [mss_pkg::FAULT_W-1:0]         set_errors,
   input  logic [mss_pkg::FAULT_W-1:0]         reset_errors,
   output mss_pkg::mss_result_type             result
);

   logic [31:0]                  legal_mask;
   logic                         is_legal;
   logic                         do_fault;
   logic [mss_pkg::FAULT_W-1:0]  f_set;
   logic [mss_pkg::FAULT_W-1:0]  f_clr;
   logic [mss_pkg::FAULT_W-1:0]  f_active;
   logic [mss_pkg::FAULT_W-1:0]  f_sticky;
   mss_pkg::mss_state_type       f_state;

   // transition table lookup
   assign legal_mask = mss_pkg::legal_targets(cur_state);
   assign is_legal   = legal_mask[requested_state];

   // operands of the fault update: explicit update or software error
   always_comb begin
      do_fault = 1'b0;
      f_set    = set_errors;
      f_clr    = reset_errors;
      case (mss_pkg::mss_cmd_type'(command))
         mss_pkg::CMD_FAULT_UPDATE: begin
            do_fault = 1'b1;
         end
         mss_pkg::CMD_CHANGE_STATE: begin
            f_set = sw_err_mask;
            f_clr = '0;
            // start and stop requests raise no software error when refused
            do_fault = !is_legal && !(requested_state inside {
               mss_pkg::ST_IDLE_START, mss_pkg::ST_IDLE_ALIGNMENT, mss_pkg::ST_ANY_STOP});
         end
         default: begin
            do_fault = 1'b0;
         end
      endcase
   end

   // fault update: set, clear, sticky history, fault state moves
   always_comb begin
      f_active = (cur_active | f_set) & ~f_clr;
      f_sticky = cur_sticky | f_set;
      f_state  = cur_state;
      if (cur_state == mss_pkg::ST_FAULT_NOW) begin
         if (f_active == '0) f_state = mss_pkg::ST_FAULT_OVER;
      end else if (f_active != '0) begin
         f_state = mss_pkg::ST_FAULT_NOW;
      end
   end

   // result per command
   always_comb begin
      result.accepted = 1'b0;
      result.state    = cur_state;
      result.active   = cur_active;
      result.sticky   = cur_sticky;
      if (do_fault) begin
         result.state  = f_state;
         result.active = f_active;
         result.sticky = f_sticky;
      end
      case (mss_pkg::mss_cmd_type'(command))
         mss_pkg::CMD_CHANGE_STATE: begin
            if (is_legal) begin
               result.accepted = 1'b1;
               result.state    = mss_pkg::mss_state_type'(requested_state);
            end
         end
         mss_pkg::CMD_FAULT_UPDATE: begin
            result.accepted = 1'b1;
         end
         mss_pkg::CMD_FAULT_ACK: begin
            if (cur_state == mss_pkg::ST_FAULT_OVER) begin
               result.accepted = 1'b1;
               result.state    = mss_pkg::ST_STOP_IDLE;
               result.sticky   = '0;
            end
         end
         default: begin
            result.accepted = 1'b0;
         end
      endcase
   end

endmodule

FILE: rtl/motor_state_sequencer_with_faults_unit.sv
// ----------------------------------------------------------------------------
// motor_state_sequencer_with_faults_unit
// Motor control supervisor: 21-state sequencer with fault set, clear and ack.
// ----------------------------------------------------------------------------
// Takes one command per clock and returns one result per command, in the cycle
// after its transfer. The machine state and both fault words are updated at
// the input transfer and copied into the result register at the same edge,
// so throughput is one item per cycle; the input is stalled only while a result
// is held and the result side is itself stalled. The software error mask is
// written through the csr port and resets to 0x0080.
module motor_state_sequencer_with_faults_unit (
   input  logic                                clock,
   input  logic                                reset,
   // command channel
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [1:0]                          req_command,
   input  logic [mss_pkg::STATE_W-1:0]         req_requested_state,
   input  logic [mss_pkg::FAULT_W-1:0]         req_set_errors,
   input  logic [mss_pkg::FAULT_W-1:0]         req_reset_errors,
   // result channel
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic                                rsp_accepted,
   output logic [mss_pkg::STATE_W-1:0]         rsp_current_state,
   output logic [mss_pkg::FAULT_W-1:0]         rsp_active_faults,
   output logic [mss_pkg::FAULT_W-1:0]         rsp_fault_history,
   // configuration
   input  logic                                csr_write_enable,
   input  logic [mss_pkg::FAULT_W-1:0]         csr_write_data
);

   mss_pkg::mss_state_type        state_ff;
   logic [mss_pkg::FAULT_W-1:0]   active_ff;
   logic [mss_pkg::FAULT_W-1:0]   sticky_ff;
   logic [mss_pkg::FAULT_W-1:0]   mask_ff;
   logic                          rsp_valid_ff;
   logic                          rsp_valid_in;
   mss_pkg::mss_result_type       rsp_data_ff;
   mss_pkg::mss_result_type       step_result;
   logic                          req_xfer;
   logic                          rsp_xfer;

   // handshake
   assign req_stall = rsp_valid_ff && rsp_stall;
   assign req_xfer  = req_valid && !req_stall;
   assign rsp_xfer  = rsp_valid_ff && !rsp_stall;

   // per-command update logic
   mss_step u_step (
      .cur_state       (state_ff),
      .cur_active      (active_ff),
      .cur_sticky      (sticky_ff),
      .sw_err_mask     (mask_ff),
      .command         (req_command),
      .requested_state (req_requested_state),
      .set_errors      (req_set_errors),
      .reset_errors    (req_reset_errors),
      .result          (step_result)
   );

   // machine state and fault words
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= mss_pkg::ST_IDLE;
         active_ff <= '0;
         sticky_ff <= '0;
      end else if (req_xfer) begin
         state_ff  <= step_result.state;
         active_ff <= step_result.active;
         sticky_ff <= step_result.sticky;
      end
   end

   // software error mask register
   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff <= mss_pkg::SW_ERR_MASK_RESET;
      end else if (csr_write_enable) begin
         mask_ff <= csr_write_data;
      end
   end

   // result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (req_xfer) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_xfer) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         rsp_data_ff <= step_result;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_accepted      = rsp_data_ff.accepted;
   assign rsp_current_state = rsp_data_ff.state;
   assign rsp_active_faults = rsp_data_ff.active;
   assign rsp_fault_history = rsp_data_ff.sticky;

   // held result always mirrors the machine registers
   a_rsp_mirrors_state: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_data_ff.state == state_ff && rsp_data_ff.active == active_ff
                        && rsp_data_ff.sticky == sticky_ff))
      else $error("held result differs from machine registers");

   // active faults only while in fault_now
   a_faults_imply_fault_now: assert property (@(posedge clock) disable iff (reset)
      (active_ff != '0) |-> (state_ff == mss_pkg::ST_FAULT_NOW))
      else $error("active faults outside fault_now");

   // every active fault is recorded in the history
   a_history_covers_active: assert property (@(posedge clock) disable iff (reset)
      (active_ff & ~sticky_ff) == '0)
      else $error("active fault missing from history");

   // a drained result with no new transfer empties the result register
   a_result_drains: assert property (@(posedge clock) disable iff (reset)
      (rsp_xfer && !req_xfer) |=> !rsp_valid_ff)
      else $error("result register did not empty after transfer");

endmodule

FILE: tb/mss_result_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// mss_result_checker
// Watches the command and result channels of the motor state sequencer,
// predicts each result from its own copy of the machine state, fault words
// and software error mask, and compares every result transfer in order.
// ----------------------------------------------------------------------------
module mss_result_checker
   import mss_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   // command channel
   input  logic                req_valid,
   input  logic                req_stall,
   input  logic [1:0]          req_command,
   input  logic [STATE_W-1:0]  req_requested_state,
   input  logic [FAULT_W-1:0]  req_set_errors,
   input  logic [FAULT_W-1:0]  req_reset_errors,
   // result channel
   input  logic                rsp_valid,
   input  logic                rsp_stall,
   input  logic                rsp_accepted,
   input  logic [STATE_W-1:0]  rsp_current_state,
   input  logic [FAULT_W-1:0]  rsp_active_faults,
   input  logic [FAULT_W-1:0]  rsp_fault_history,
   // configuration
   input  logic                csr_write_enable,
   input  logic [FAULT_W-1:0]  csr_write_data,
   // status towards the testbench top
   output int                  error_count,
   output int                  outstanding
);

   // shadow of the supervisor
   mss_state_type       state_q;
   logic [FAULT_W-1:0]  active_q;
   logic [FAULT_W-1:0]  history_q;
   logic [FAULT_W-1:0]  sw_mask_q;

   // results still owed by the block, oldest first
   mss_result_type      pending_results[$];
   mss_result_type      oldest;

   initial begin
      error_count = 0;
      outstanding = 0;
   end

   task automatic report_failure(input string msg);
      $display("%0t ns  check failed: %s", $time, msg);
      error_count++;
   endtask

   function automatic logic [31:0] state_bit(input mss_state_type s);
      return 32'd1 << s;
   endfunction

   // targets that a change request may reach from a given state
   function automatic logic [31:0] allowed_moves(input mss_state_type from_state);
      logic [31:0] moves;
      moves = '0;
      case (from_state)
         ST_IDLE:               moves = state_bit(ST_IDLE_START) | state_bit(ST_IDLE_ALIGNMENT)
                                      | state_bit(ST_ICL_WAIT);
         ST_IDLE_START:         moves = state_bit(ST_ANY_STOP) | state_bit(ST_BOOT_CAP)
                                      | state_bit(ST_START) | state_bit(ST_OFFSET_CALIB)
                                      | state_bit(ST_IDLE_ALIGNMENT);
         ST_IDLE_ALIGNMENT:     moves = state_bit(ST_ANY_STOP) | state_bit(ST_ALIGN_BOOT_CAP)
                                      | state_bit(ST_ALIGN_OFFSET_CALIB);
         ST_ICL_WAIT:           moves = state_bit(ST_IDLE);
         ST_ALIGN_BOOT_CAP:     moves = state_bit(ST_ALIGN_OFFSET_CALIB) | state_bit(ST_ANY_STOP);
         ST_ALIGN_OFFSET_CALIB: moves = state_bit(ST_ALIGN_CLEAR) | state_bit(ST_ANY_STOP);
         ST_ALIGN_CLEAR:        moves = state_bit(ST_ALIGNMENT) | state_bit(ST_ANY_STOP);
         ST_ALIGNMENT:          moves = state_bit(ST_ANY_STOP);
         ST_BOOT_CAP:           moves = state_bit(ST_OFFSET_CALIB) | state_bit(ST_ANY_STOP);
         ST_OFFSET_CALIB:       moves = state_bit(ST_CLEAR) | state_bit(ST_ANY_STOP)
                                      | state_bit(ST_WAIT_STOP);
         ST_WAIT_STOP:          moves = state_bit(ST_CLEAR) | state_bit(ST_ANY_STOP);
         ST_CLEAR:              moves = state_bit(ST_START) | state_bit(ST_ANY_STOP);
         ST_START:              moves = state_bit(ST_SWITCH_OVER) | state_bit(ST_ANY_STOP)
                                      | state_bit(ST_START_RUN);
         ST_SWITCH_OVER:        moves = state_bit(ST_START) | state_bit(ST_ANY_STOP)
                                      | state_bit(ST_START_RUN);
         ST_START_RUN:          moves = state_bit(ST_RUN) | state_bit(ST_ANY_STOP);
         ST_RUN:                moves = state_bit(ST_ANY_STOP);
         ST_ANY_STOP:           moves = state_bit(ST_STOP);
         ST_STOP:               moves = state_bit(ST_STOP_IDLE);
         ST_STOP_IDLE:          moves = state_bit(ST_IDLE) | state_bit(ST_ICL_WAIT);
         // both fault states refuse every request
         default:               moves = '0;
      endcase
      return moves;
   endfunction

   // set and clear fault bits, keep the history and move between the fault states
   function automatic void update_faults(input logic [FAULT_W-1:0] set_bits,
                                         input logic [FAULT_W-1:0] clr_bits);
      active_q  = (active_q | set_bits) & ~clr_bits;
      history_q = history_q | set_bits;
      if (state_q == ST_FAULT_NOW) begin
         if (active_q == '0) state_q = ST_FAULT_OVER;
      end else if (active_q != '0) begin
         state_q = ST_FAULT_NOW;
      end
   endfunction

   // advance the shadow by one command and return the result it must produce
   function automatic mss_result_type predict_transfer(input logic [1:0]         cmd,
                                                       input logic [STATE_W-1:0] target,
                                                       input logic [FAULT_W-1:0] set_bits,
                                                       input logic [FAULT_W-1:0] clr_bits);
      mss_result_type res;
      logic [31:0]    moves;
      res.accepted = 1'b0;
      moves = allowed_moves(state_q);
      case (cmd)
         CMD_CHANGE_STATE: begin
            if (moves[target]) begin
               state_q = mss_state_type'(target);
               res.accepted = 1'b1;
            end else if (target != ST_IDLE_START && target != ST_IDLE_ALIGNMENT
                         && target != ST_ANY_STOP) begin
               // refused request that is not a start or stop command
               update_faults(sw_mask_q, '0);
            end
         end
         CMD_FAULT_UPDATE: begin
            update_faults(set_bits, clr_bits);
            res.accepted = 1'b1;
         end
         CMD_FAULT_ACK: begin
            if (state_q == ST_FAULT_OVER) begin
               state_q = ST_STOP_IDLE;
               history_q = '0;
               res.accepted = 1'b1;
            end
         end
         default: begin
            // unused code leaves everything as it is
         end
      endcase
      res.state  = state_q;
      res.active = active_q;
      res.sticky = history_q;
      return res;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         state_q   = ST_IDLE;
         active_q  = '0;
         history_q = '0;
         sw_mask_q = SW_ERR_MASK_RESET;
         pending_results.delete();
      end else begin
         // result transfer against the oldest prediction
         if (rsp_valid && !rsp_stall) begin
            if (pending_results.size() == 0) begin
               report_failure("result transfer with no result expected");
            end else begin
               oldest = pending_results.pop_front();
               if (rsp_accepted !== oldest.accepted)
                  report_failure($sformatf("accepted got %0b want %0b",
                                           rsp_accepted, oldest.accepted));
               if (rsp_current_state !== oldest.state)
                  report_failure($sformatf("current_state got %0d want %0d",
                                           rsp_current_state, oldest.state));
               if (rsp_active_faults !== oldest.active)
                  report_failure($sformatf("active_faults got 0x%04h want 0x%04h",
                                           rsp_active_faults, oldest.active));
               if (rsp_fault_history !== oldest.sticky)
                  report_failure($sformatf("fault_history got 0x%04h want 0x%04h",
                                           rsp_fault_history, oldest.sticky));
            end
         end
         // mask write
         if (csr_write_enable) sw_mask_q = csr_write_data;
         // command transfer
         if (req_valid && !req_stall)
            pending_results.push_back(predict_transfer(req_command, req_requested_state,
                                                       req_set_errors, req_reset_errors));
      end
      outstanding = pending_results.size();
   end

endmodule

FILE: tb/tb_motor_state_sequencer_with_faults_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_motor_state_sequencer_with_faults_unit
// Drives directed and random command streams into the motor state sequencer
// under random idling on both channels and across several software error
// masks; a checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_motor_state_sequencer_with_faults_unit;
   import mss_pkg::*;

   localparam int CYCLE_LIMIT = 200000;
   localparam int PHASE_ITEMS = 145;

   logic                clock;
   logic                reset;
   logic                req_valid;
   logic                req_stall;
   logic [1:0]          req_command;
   logic [STATE_W-1:0]  req_requested_state;
   logic [FAULT_W-1:0]  req_set_errors;
   logic [FAULT_W-1:0]  req_reset_errors;
   logic                rsp_valid;
   logic                rsp_stall;
   logic                rsp_accepted;
   logic [STATE_W-1:0]  rsp_current_state;
   logic [FAULT_W-1:0]  rsp_active_faults;
   logic [FAULT_W-1:0]  rsp_fault_history;
   logic                csr_write_enable;
   logic [FAULT_W-1:0]  csr_write_data;

   int  error_count;
   int  outstanding;
   int  cycle_count = 0;
   int  commands_sent = 0;
   bit  idling_on = 1'b1;

   motor_state_sequencer_with_faults_unit u_dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_command         (req_command),
      .req_requested_state (req_requested_state),
      .req_set_errors      (req_set_errors),
      .req_reset_errors    (req_reset_errors),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_accepted        (rsp_accepted),
      .rsp_current_state   (rsp_current_state),
      .rsp_active_faults   (rsp_active_faults),
      .rsp_fault_history   (rsp_fault_history),
      .csr_write_enable    (csr_write_enable),
      .csr_write_data      (csr_write_data)
   );

   mss_result_checker u_checker (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_command         (req_command),
      .req_requested_state (req_requested_state),
      .req_set_errors      (req_set_errors),
      .req_reset_errors    (req_reset_errors),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_accepted        (rsp_accepted),
      .rsp_current_state   (rsp_current_state),
      .rsp_active_faults   (rsp_active_faults),
      .rsp_fault_history   (rsp_fault_history),
      .csr_write_enable    (csr_write_enable),
      .csr_write_data      (csr_write_data),
      .error_count         (error_count),
      .outstanding         (outstanding)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // result side stalls in bursts, with free stretches between them
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(posedge clock);
         if (idling_on && $urandom_range(0, 2) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 8)) @(posedge clock);
            rsp_stall <= 1'b0;
         end
         repeat ($urandom_range(0, 7)) @(posedge clock);
      end
   end

   function automatic logic [FAULT_W-1:0] any_faults();
      return FAULT_W'($urandom_range(0, 16'hFFFF));
   endfunction

   function automatic logic [STATE_W-1:0] any_target();
      return STATE_W'($urandom_range(0, 31));
   endfunction

   // one command transfer, with a random gap ahead of it while idling is on
   task automatic send_command(input mss_cmd_type          cmd,
                               input logic [STATE_W-1:0]  target,
                               input logic [FAULT_W-1:0]  set_bits,
                               input logic [FAULT_W-1:0]  clr_bits);
      if (idling_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
      req_valid           <= 1'b1;
      req_command         <= cmd;
      req_requested_state <= target;
      req_set_errors      <= set_bits;
      req_reset_errors    <= clr_bits;
      do @(posedge clock); while (req_stall);
      if (cmd != CMD_UNUSED) commands_sent++;
   endtask

   // hold off the sender until every result has come back
   task automatic drain_results();
      req_valid <= 1'b0;
      do @(negedge clock); while (outstanding != 0);
      @(posedge clock);
   endtask

   task automatic write_sw_mask(input logic [FAULT_W-1:0] mask);
      drain_results();
      csr_write_enable <= 1'b1;
      csr_write_data   <= mask;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // random command of any kind, fault words often sparse
   task automatic send_noise();
      logic [FAULT_W-1:0] set_bits;
      logic [FAULT_W-1:0] clr_bits;
      set_bits = any_faults();
      clr_bits = any_faults();
      if ($urandom_range(0, 1) == 0) set_bits = set_bits & any_faults() & any_faults();
      send_command(mss_cmd_type'($urandom_range(0, 3)), any_target(), set_bits, clr_bits);
   endtask

   // bring the machine home to idle, then walk one of the legal routes
   task automatic run_route();
      mss_state_type       path[$];
      logic [FAULT_W-1:0]  set_bits;
      int                  stop_at;
      case ($urandom_range(0, 5))
         0: path = '{ST_IDLE_START, ST_BOOT_CAP, ST_OFFSET_CALIB, ST_CLEAR, ST_START,
                     ST_SWITCH_OVER, ST_START_RUN, ST_RUN, ST_ANY_STOP, ST_STOP,
                     ST_STOP_IDLE, ST_ICL_WAIT, ST_IDLE};
         1: path = '{ST_IDLE_ALIGNMENT, ST_ALIGN_BOOT_CAP, ST_ALIGN_OFFSET_CALIB,
                     ST_ALIGN_CLEAR, ST_ALIGNMENT, ST_ANY_STOP, ST_STOP, ST_STOP_IDLE,
                     ST_IDLE};
         2: path = '{ST_IDLE_START, ST_OFFSET_CALIB, ST_WAIT_STOP, ST_CLEAR, ST_START,
                     ST_START_RUN, ST_ANY_STOP, ST_STOP, ST_STOP_IDLE, ST_IDLE};
         3: path = '{ST_IDLE_START, ST_START, ST_SWITCH_OVER, ST_START, ST_SWITCH_OVER,
                     ST_START_RUN, ST_RUN, ST_ANY_STOP, ST_STOP, ST_STOP_IDLE,
                     ST_ICL_WAIT, ST_IDLE};
         4: path = '{ST_IDLE_START, ST_IDLE_ALIGNMENT, ST_ALIGN_OFFSET_CALIB, ST_ANY_STOP,
                     ST_STOP, ST_STOP_IDLE, ST_IDLE};
         default: path = '{ST_ICL_WAIT, ST_IDLE, ST_IDLE_START, ST_ANY_STOP, ST_STOP,
                           ST_STOP_IDLE, ST_IDLE};
      endcase
      // homing: raise a fault, clear all, acknowledge, drop to idle
      set_bits = any_faults();
      if (set_bits == '0) set_bits = 16'h0001;
      send_command(CMD_FAULT_UPDATE, any_target(), set_bits, any_faults() & ~set_bits);
      send_command(CMD_FAULT_UPDATE, any_target(), any_faults(), 16'hFFFF);
      send_command(CMD_FAULT_ACK, any_target(), any_faults(), any_faults());
      send_command(CMD_CHANGE_STATE, ST_IDLE, any_faults(), any_faults());
      // route, sometimes cut short or broken by noise
      stop_at = $urandom_range(path.size() / 2, path.size());
      for (int i = 0; i < stop_at; i++) begin
         if ($urandom_range(0, 9) == 0) send_noise();
         send_command(CMD_CHANGE_STATE, path[i], any_faults(), any_faults());
      end
      // now and then a burst of pure noise
      if ($urandom_range(0, 4) == 0)
         repeat ($urandom_range(3, 10)) send_noise();
   endtask

   // stimulus and verdict
   initial begin
      logic [FAULT_W-1:0] phase_masks[$];
      reset               = 1'b1;
      req_valid           = 1'b0;
      req_command         = CMD_CHANGE_STATE;
      req_requested_state = ST_IDLE;
      req_set_errors      = '0;
      req_reset_errors    = '0;
      csr_write_enable    = 1'b0;
      csr_write_data      = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // acknowledge outside fault_over, unused code
      send_command(CMD_FAULT_ACK, ST_IDLE, 16'h0000, 16'h0000);
      send_command(CMD_UNUSED, 5'd31, 16'hFFFF, 16'hFFFF);
      // legal hop and return, refused stop command raises nothing
      send_command(CMD_CHANGE_STATE, ST_ICL_WAIT, 16'hFFFF, 16'hFFFF);
      send_command(CMD_CHANGE_STATE, ST_IDLE, 16'hFFFF, 16'h0000);
      send_command(CMD_CHANGE_STATE, ST_ANY_STOP, 16'h0000, 16'hFFFF);
      // out of range target raises the software error
      send_command(CMD_CHANGE_STATE, 5'd21, 16'h0000, 16'h0000);
      // fault_now: start command refused silently, others raise again
      send_command(CMD_CHANGE_STATE, ST_IDLE_ALIGNMENT, 16'h0000, 16'h0000);
      send_command(CMD_CHANGE_STATE, 5'd31, 16'h0000, 16'h0000);
      // set everything, clear part, clear the rest
      send_command(CMD_FAULT_UPDATE, ST_IDLE, 16'hFFFF, 16'h0000);
      send_command(CMD_FAULT_UPDATE, ST_IDLE, 16'h0000, 16'h7FFF);
      send_command(CMD_FAULT_UPDATE, ST_IDLE, 16'h0000, 16'hFFFF);
      // fault_over: stop command refused silently, other request faults again
      send_command(CMD_CHANGE_STATE, ST_ANY_STOP, 16'h0000, 16'h0000);
      send_command(CMD_CHANGE_STATE, ST_STOP_IDLE, 16'h0000, 16'h0000);
      send_command(CMD_FAULT_UPDATE, ST_IDLE, 16'h0000, 16'hFFFF);
      // acknowledge, then acknowledge again with nothing to acknowledge
      send_command(CMD_FAULT_ACK, ST_IDLE, 16'h0000, 16'h0000);
      send_command(CMD_FAULT_ACK, ST_IDLE, 16'h0000, 16'h0000);
      // same bit set and cleared in one update outside the fault states
      send_command(CMD_FAULT_UPDATE, ST_IDLE, 16'h0001, 16'h0001);
      // run up and stop again
      send_command(CMD_CHANGE_STATE, ST_IDLE, 16'h0000, 16'h0000);
      send_command(CMD_CHANGE_STATE, ST_IDLE_START, 16'h0000, 16'h0000);
      send_command(CMD_CHANGE_STATE, ST_START, 16'h0000, 16'h0000);
      send_command(CMD_CHANGE_STATE, ST_START_RUN, 16'h0000, 16'h0000);
      send_command(CMD_CHANGE_STATE, ST_RUN, 16'h0000, 16'h0000);
      send_command(CMD_CHANGE_STATE, ST_ANY_STOP, 16'h0000, 16'h0000);

      // zero mask: refused requests change nothing, also in fault_now
      write_sw_mask(16'h0000);
      send_command(CMD_CHANGE_STATE, ST_RUN, 16'h0000, 16'h0000);
      send_command(CMD_FAULT_UPDATE, ST_IDLE, 16'h0100, 16'h0000);
      send_command(CMD_CHANGE_STATE, 5'd31, 16'h0000, 16'h0000);

      // random phases, one mask each; the last runs without idling
      phase_masks = '{16'hFFFF, any_faults(), 16'h0000, 16'h8000, SW_ERR_MASK_RESET,
                      any_faults()};
      foreach (phase_masks[p]) begin
         write_sw_mask(phase_masks[p]);
         if (p == phase_masks.size() - 1) idling_on = 1'b0;
         while (commands_sent < 30 + (p + 1) * PHASE_ITEMS) run_route();
      end

      drain_results();
      repeat (4) @(posedge clock);
      if (error_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
